>>> hdl/bht_pkg.sv
// Package for the bucketed hash table engine: sizes, codes, hash constants.
// No dependencies.
`default_nettype none
package bht_pkg;
	localparam int unsigned NumBins     = 256;
	localparam int unsigned SlotsPerBin = 4;
	localparam int unsigned TableSlots  = NumBins * SlotsPerBin;
	localparam int unsigned BinW        = $clog2(NumBins);
	localparam int unsigned SlotW       = (SlotsPerBin > 1) ? $clog2(SlotsPerBin) : 1;
	localparam int unsigned AddrW       = $clog2(TableSlots);
	localparam int unsigned CntW        = 11;

	localparam logic [63:0] MmC1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MmC2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] MmF1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MmF2 = 64'hc4ceb9fe1a85ec53;

	localparam logic [2:0] CmdUpsert = 3'd0;
	localparam logic [2:0] CmdInsert = 3'd1;
	localparam logic [2:0] CmdUpdate = 3'd2;
	localparam logic [2:0] CmdQuery  = 3'd3;
	localparam logic [2:0] CmdDelete = 3'd4;

	localparam logic [2:0] StOk      = 3'd0;
	localparam logic [2:0] StExists  = 3'd1;
	localparam logic [2:0] StMissing = 3'd2;
	localparam logic [2:0] StFull    = 3'd3;
	localparam logic [2:0] StBadKey  = 3'd4;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] key;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]     status;
		logic           found;
		logic [63:0]    value_out;
		logic [CntW-1:0] entry_count;
	} rsp_t;

	// Hash unit control from the sequencer.
	typedef struct packed {
		logic        start;
		logic [63:0] key;
		logic [31:0] seed;
	} hash_ctl_t;

	typedef struct packed {
		logic            done;
		logic [BinW-1:0] bin;
	} hash_sts_t;
endpackage
`default_nettype wire

>>> hdl/bht_if.sv
// Valid/ready channel interfaces, each carrying a payload of a fixed type.
// Depends on bht_pkg.
`default_nettype none
interface bht_req_if;
	logic          valid;
	logic          ready;
	bht_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bht_rsp_if;
	logic          valid;
	logic          ready;
	bht_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bht_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/bht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bht_ram #(
	parameter int unsigned Width = 64,
	parameter int unsigned Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output      logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> hdl/bht_hash.sv
// Iterative MurmurHash3 x64_128 (second word) over one 64-bit key.
// One shared 32x32 multiplier builds each 64x64 product from partial products. Depends on bht_pkg.
`default_nettype none
module bht_hash (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bht_pkg::hash_ctl_t ctl,
	output      bht_pkg::hash_sts_t sts
);
	// Micro-step list; each MUL step runs its partial products in turn (lo*lo, lo*hi, hi*lo).
	typedef enum logic [7:0] {
		OP_K1   = 8'b0000_0001,
		OP_K2   = 8'b0000_0010,
		OP_MA1  = 8'b0000_0100,
		OP_MA2  = 8'b0000_1000,
		OP_MB1  = 8'b0001_0000,
		OP_MB2  = 8'b0010_0000,
		OP_FIN  = 8'b0100_0000,
		OP_IDLE = 8'b1000_0000
	} op_t;

	op_t         op_q;
	logic [1:0]  ph_q;
	logic        done_q;
	logic [63:0] a_q, b_q, x_q, acc_q;
	logic [31:0] m_a, m_b;
	logic [63:0] prod, cst, xs;

	always_comb begin
		case (op_q)
			OP_K1:          cst = bht_pkg::MmC1;
			OP_K2:          cst = bht_pkg::MmC2;
			OP_MA1, OP_MB1: cst = bht_pkg::MmF1;
			default:        cst = bht_pkg::MmF2;
		endcase
		xs = x_q ^ (x_q >> 33);
		case (ph_q)
			2'd0:    begin m_a = xs[31:0];  m_b = cst[31:0];  end
			2'd1:    begin m_a = xs[31:0];  m_b = cst[63:32]; end
			default: begin m_a = xs[63:32]; m_b = cst[31:0];  end
		endcase
		prod = 64'(m_a) * 64'(m_b);
	end

	logic [63:0] seed64, a0, b0;
	always_comb begin
		seed64 = {32'd0, ctl.seed};
		a0 = seed64 ^ 64'd8;
		b0 = seed64 ^ 64'd8;
	end

	logic [63:0] acc_d;
	always_comb begin
		case (ph_q)
			2'd0:    acc_d = prod;
			default: acc_d = acc_q + {prod[31:0], 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_IDLE;
			ph_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !ctl.start && (op_q == OP_FIN);
			if (ctl.start) begin
				op_q <= OP_K1;
				ph_q <= '0;
			end else if (op_q != OP_IDLE && op_q != OP_FIN) begin
				if (ph_q == 2'd2) begin
					ph_q <= '0;
					case (op_q)
						OP_K1:   op_q <= OP_K2;
						OP_K2:   op_q <= OP_MA1;
						OP_MA1:  op_q <= OP_MA2;
						OP_MA2:  op_q <= OP_MB1;
						OP_MB1:  op_q <= OP_MB2;
						default: op_q <= OP_FIN;
					endcase
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end else if (op_q == OP_FIN) begin
				op_q <= OP_IDLE;
			end
		end
	end

	// Datapath: x_q feeds the multiplier through the xorshift. The key load and the K1
	// result are stored pre-xorshifted so that the multiplier sees the raw value.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= ctl.key ^ (ctl.key >> 33);
			a_q <= a0;
			b_q <= b0;
		end else begin
			if (ph_q != 2'd2) begin
				acc_q <= acc_d;
			end else begin
				case (op_q)
					OP_K1: x_q <= {acc_d[32:0], acc_d[63:33]} ^ (({acc_d[32:0], acc_d[63:33]}) >> 33);
					OP_K2: begin
						// a = (seed ^ k ^ 8) + (seed ^ 8); then xorshift via xs
						x_q <= (a_q ^ acc_d) + b_q;
						b_q <= b_q + ((a_q ^ acc_d) + b_q);
						a_q <= (a_q ^ acc_d) + b_q;
					end
					OP_MA1:  x_q <= acc_d;
					OP_MA2: begin
						a_q <= acc_d ^ (acc_d >> 33);
						x_q <= b_q;
					end
					OP_MB1:  x_q <= acc_d;
					default: b_q <= acc_d ^ (acc_d >> 33);
				endcase
			end
		end
	end

	logic [63:0] a_fin;
	assign a_fin = a_q + b_q;
	assign sts.done = done_q;
	assign sts.bin = bht_pkg::BinW'(b_q + a_fin);
endmodule
`default_nettype wire

>>> hdl/bucketed_hash_table_engine.sv
// Top level of the bucketed hash table engine; depends on bht_pkg, bht_if, bht_ram, bht_hash.
// Steps: hash, bin scan (a key read per slot), decide, and a value read on a query hit; then the
//   result transaction. Key zero skips the table and goes straight to the result.
// Throughput: one command at a time; the next is taken only after the result is accepted. The pace
//   is set by the shared 32x32 multiplier and the single-port key RAM scan.
// Reset: asynchronous, active low; a pass then clears every key RAM slot, no commands taken.
`default_nettype none
module bucketed_hash_table_engine (
	input wire logic clk,
	input wire logic arst_n,
	bht_cfg_if.sink  cfg,
	bht_req_if.sink  req,
	bht_rsp_if.source rsp
);
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_HASH  = 7'b0000100,
		S_SCAN  = 7'b0001000,
		S_DEC   = 7'b0010000,
		S_VRD   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	localparam int unsigned AW = bht_pkg::AddrW;
	localparam int unsigned SW = bht_pkg::SlotW;

	state_t state_q;
	logic [31:0] seed_q;
	bht_pkg::req_t cur_q;
	logic [AW-1:0] clr_q;
	logic [SW:0]   slot_q;    // slot being read
	logic          rd_issue;  // a slot read goes out this cycle
	logic          rd_pend_q; // read data valid this cycle
	logic [SW-1:0] rd_slot_q;
	logic          hit_q, emp_q;
	logic [SW-1:0] hit_slot_q, emp_slot_q;
	logic [bht_pkg::BinW-1:0] bin_q;
	logic [bht_pkg::CntW-1:0] cnt_q;
	bht_pkg::rsp_t out_q;

	bht_pkg::hash_ctl_t hctl;
	bht_pkg::hash_sts_t hsts;

	logic          k_we, v_we;
	logic [AW-1:0] k_addr, v_addr;
	logic [63:0]   k_wdata, k_rdata, v_rdata;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid) begin
			seed_q <= cfg.data;
		end
	end

	assign hctl.start = (state_q == S_IDLE) && req.valid;
	assign hctl.key   = req.data.key;
	assign hctl.seed  = seed_q;

	bht_hash u_hash (.clk(clk), .arst_n(arst_n), .ctl(hctl), .sts(hsts));

	function automatic logic [AW-1:0] slot_addr(input logic [bht_pkg::BinW-1:0] b,
		input logic [SW-1:0] s);
		slot_addr = AW'(b) * AW'(bht_pkg::SlotsPerBin) + AW'(s);
	endfunction

	// Decision, taken in S_DEC.
	logic is_write, is_del, do_ins, do_upd, do_del;
	logic [2:0] st_d;
	always_comb begin
		is_write = cur_q.cmd == bht_pkg::CmdUpsert || cur_q.cmd == bht_pkg::CmdInsert
			|| cur_q.cmd == bht_pkg::CmdUpdate;
		is_del = cur_q.cmd == bht_pkg::CmdDelete;
		do_ins = 1'b0; do_upd = 1'b0; do_del = 1'b0;
		st_d = bht_pkg::StOk;
		if (is_write) begin
			if (hit_q) begin
				if (cur_q.cmd == bht_pkg::CmdInsert) st_d = bht_pkg::StExists;
				else do_upd = 1'b1;
			end else if (cur_q.cmd == bht_pkg::CmdUpdate) begin
				st_d = bht_pkg::StMissing;
			end else if (!emp_q) begin
				st_d = bht_pkg::StFull;
			end else begin
				do_ins = 1'b1;
			end
		end else if (is_del) begin
			if (hit_q) do_del = 1'b1;
			else st_d = bht_pkg::StMissing;
		end else if (!hit_q) begin
			st_d = bht_pkg::StMissing;
		end
	end

	always_comb begin
		k_we = 1'b0; k_wdata = '0; v_we = 1'b0;
		k_addr = slot_addr(bin_q, slot_q[SW-1:0]);
		v_addr = slot_addr(bin_q, hit_slot_q);
		case (state_q)
			S_CLEAR: begin k_we = 1'b1; k_addr = clr_q; end
			S_DEC: begin
				if (do_ins) begin
					k_we = 1'b1; k_wdata = cur_q.key; v_we = 1'b1;
					k_addr = slot_addr(bin_q, emp_slot_q);
					v_addr = k_addr;
				end else if (do_del) begin
					k_we = 1'b1; k_addr = slot_addr(bin_q, hit_slot_q);
				end else if (do_upd) begin
					v_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	bht_ram #(.Width(64), .Depth(bht_pkg::TableSlots)) u_key_ram (
		.clk(clk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata));
	bht_ram #(.Width(64), .Depth(bht_pkg::TableSlots)) u_val_ram (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(cur_q.value), .rdata(v_rdata));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.data  = out_q;

	assign rd_issue = (state_q == S_SCAN) && (slot_q < (SW+1)'(bht_pkg::SlotsPerBin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= rd_issue;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(bht_pkg::TableSlots - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						// Key zero skips the table entirely.
						if (req.data.key == '0) state_q <= S_OUT;
						else state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hsts.done) state_q <= S_SCAN;
				end
				S_SCAN: begin
					// Issue reads for each slot, then drain the last read.
					if (!rd_issue && !rd_pend_q) state_q <= S_DEC;
				end
				S_DEC: begin
					if (do_ins) cnt_q <= cnt_q + bht_pkg::CntW'(1);
					if (do_del) cnt_q <= cnt_q - bht_pkg::CntW'(1);
					state_q <= (!is_write && !is_del && hit_q) ? S_VRD : S_OUT;
				end
				S_VRD: state_q <= S_OUT;
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= req.data;
				slot_q <= '0;
				hit_q <= 1'b0; emp_q <= 1'b0;
				hit_slot_q <= '0; emp_slot_q <= '0;
				out_q <= '{status: bht_pkg::StBadKey, found: 1'b0, value_out: '0,
					entry_count: cnt_q};
			end
			S_HASH: bin_q <= hsts.bin;
			S_SCAN: begin
				if (rd_issue) slot_q <= slot_q + (SW+1)'(1);
				rd_slot_q <= slot_q[SW-1:0];
				if (rd_pend_q) begin
					if (!hit_q && k_rdata == cur_q.key) begin
						hit_q <= 1'b1; hit_slot_q <= rd_slot_q;
					end
					if (!emp_q && k_rdata == '0) begin
						emp_q <= 1'b1; emp_slot_q <= rd_slot_q;
					end
				end
			end
			S_DEC: begin
				out_q.status <= st_d;
				out_q.found <= hit_q;
				out_q.value_out <= '0;
				out_q.entry_count <= do_ins ? cnt_q + bht_pkg::CntW'(1)
					: (do_del ? cnt_q - bht_pkg::CntW'(1) : cnt_q);
			end
			S_VRD: out_q.value_out <= v_rdata;
			default: ;
		endcase
	end

	// Assertions
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed while stalled");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) != S_DEC |-> $stable(cnt_q)) else $error("count moved outside decide");
	a_badkey: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == bht_pkg::StBadKey |-> !rsp.data.found)
		else $error("bad key reported found");
endmodule
`default_nettype wire
